@@ rtl/spfe_pkg.sv @@
// shared types and constants for the spring pendulum force evaluator
// no dependencies; imported by every module in rtl
package spfe_pkg;

  localparam int unsigned CfgW     = 31;
  localparam int unsigned MagW     = 33;  // |pos - anchor| per axis
  localparam int unsigned SumW     = 66;  // sum of three squared magnitudes
  localparam int unsigned RootW    = 33;  // floor square root of the sum
  localparam int unsigned QuoW     = 31;  // unit vector component, Q1.30
  localparam int unsigned SQRT_LAT = RootW;
  localparam int unsigned DIV_LAT  = QuoW;
  localparam int unsigned TOTAL_LAT = 3 + SQRT_LAT + DIV_LAT + 6;

  localparam logic [CfgW-1:0] GRAVITY_RESET = 31'd642253;
  localparam logic [CfgW-1:0] DRAG_RESET    = 31'd163840;
  localparam logic [CfgW-1:0] STIFF_RESET   = 31'd983040;
  localparam logic [CfgW-1:0] REST_RESET    = 31'd32768;

  typedef enum logic [1:0] {
    REG_GRAVITY = 2'd0,
    REG_DRAG    = 2'd1,
    REG_STIFF   = 2'd2,
    REG_REST    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] anchor_x;
    logic signed [31:0] anchor_y;
    logic signed [31:0] anchor_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_in_x;
    logic signed [31:0] vel_in_y;
    logic signed [31:0] vel_in_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] vel_out_x;
    logic signed [31:0] vel_out_y;
    logic signed [31:0] vel_out_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic               zero_length;
  } out_t;

endpackage

@@ rtl/spfe_sqrt.sv @@
// pipelined floor square root, one result bit per stage
// depends on spfe_pkg
module spfe_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [spfe_pkg::SumW-1:0]     radicand,
  output logic                          out_valid,
  output logic [spfe_pkg::RootW-1:0]    root
);
  import spfe_pkg::*;

  logic [SumW-1:0]  x_s [RootW];
  logic [RootW-1:0] r_s [RootW];
  logic             v_s [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_st
    localparam int B = RootW - 1 - k;
    logic [SumW-1:0]  x_in;
    logic [RootW-1:0] r_in;
    logic             v_in;
    logic [SumW-1:0]  trial;

    if (k == 0) begin : g_first
      assign x_in = radicand;
      assign r_in = '0;
      assign v_in = in_valid;
    end else begin : g_next
      assign x_in = x_s[k-1];
      assign r_in = r_s[k-1];
      assign v_in = v_s[k-1];
    end

    // (r + 2^b)^2 - r^2, r holds only bits above b
    assign trial = ({{(SumW-RootW){1'b0}}, r_in} << (B + 1)) | (SumW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k] <= 1'b0;
      end else begin
        v_s[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (x_in >= trial) begin
        x_s[k] <= x_in - trial;
        r_s[k] <= r_in | (RootW'(1) << B);
      end else begin
        x_s[k] <= x_in;
        r_s[k] <= r_in;
      end
    end
  end

  assign out_valid = v_s[RootW-1];
  assign root      = r_s[RootW-1];

endmodule

@@ rtl/spfe_div.sv @@
// pipelined restoring divider: (mag << 30) / divisor, one quotient bit per stage
// depends on spfe_pkg
module spfe_div (
  input  logic                         clk,
  input  logic [spfe_pkg::MagW-1:0]    dividend_mag,
  input  logic [spfe_pkg::RootW-1:0]   divisor,
  output logic [spfe_pkg::QuoW-1:0]    quot
);
  import spfe_pkg::*;

  localparam int RemW = MagW + QuoW - 1;

  logic [RemW-1:0]  rem_s [QuoW];
  logic [RootW-1:0] dvs_s [QuoW];
  logic [QuoW-1:0]  q_s   [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_st
    localparam int J = QuoW - 1 - k;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] dvs_in;
    logic [QuoW-1:0]  q_in;
    logic [RemW:0]    shifted;

    if (k == 0) begin : g_first
      assign rem_in = {dividend_mag, {(QuoW-1){1'b0}}};
      assign dvs_in = divisor;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_s[k-1];
      assign dvs_in = dvs_s[k-1];
      assign q_in   = q_s[k-1];
    end

    assign shifted = {{(RemW+1-RootW){1'b0}}, dvs_in} << J;

    always_ff @(posedge clk) begin
      dvs_s[k] <= dvs_in;
      if ({1'b0, rem_in} >= shifted) begin
        rem_s[k] <= rem_in - shifted[RemW-1:0];
        q_s[k]   <= q_in | (QuoW'(1) << J);
      end else begin
        rem_s[k] <= rem_in;
        q_s[k]   <= q_in;
      end
    end
  end

  assign quot = q_s[QuoW-1];

endmodule

@@ rtl/spring_pendulum_force_eval.sv @@
// top level of the spring pendulum force evaluator: registers, pipeline, result
// depends on spfe_pkg, spfe_sqrt, spfe_div
//
// usage
//  - one input beat per cycle: a beat is taken at a clock edge with start high
//    and busy low; busy is always low, the pipeline never refuses a beat
//  - the result beat shows on result with done high for exactly one cycle,
//    once the item has passed every stage (3 front stages, 33 square root
//    stages, 31 divider stages, 6 back stages)
//  - throughput is one beat per clock; every stage is a plain register with a
//    valid bit, nothing loops back, so items never wait on each other
//  - the receiver cannot stall: done is a strobe and result is gone next cycle
//  - synchronous reset clears every valid bit (items in flight are dropped)
//    and loads the four registers with their defaults
//  - configuration is an apb-style port: gravity 0x0, drag 0x4, stiffness 0x8,
//    rest length 0xc; 31-bit values, write only while no beat is in flight
//  - when the two positions coincide the spring term is zero and zero_length
//    is set; drag and gravity still apply
module spring_pendulum_force_eval (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  spfe_pkg::in_t   in_item,
  output logic            done,
  output spfe_pkg::out_t  result,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import spfe_pkg::*;

  typedef struct packed {
    logic [2:0][MagW-1:0] mag;
    logic [2:0]           neg;
    logic [2:0][31:0]     vel;
  } side_t;

  typedef struct packed {
    logic [2:0]           neg;
    logic [2:0][31:0]     vel;
    logic [RootW-1:0]     len;
  } dside_t;

  // configuration registers
  logic [CfgW-1:0] gravity_accel, drag_coeff, spring_stiffness, rest_length;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_accel    <= GRAVITY_RESET;
      drag_coeff       <= DRAG_RESET;
      spring_stiffness <= STIFF_RESET;
      rest_length      <= REST_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_GRAVITY: gravity_accel    <= pwdata[CfgW-1:0];
        REG_DRAG:    drag_coeff       <= pwdata[CfgW-1:0];
        REG_STIFF:   spring_stiffness <= pwdata[CfgW-1:0];
        REG_REST:    rest_length      <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_GRAVITY: prdata = {1'b0, gravity_accel};
      REG_DRAG:    prdata = {1'b0, drag_coeff};
      REG_STIFF:   prdata = {1'b0, spring_stiffness};
      REG_REST:    prdata = {1'b0, rest_length};
      default:     prdata = '0;
    endcase
  end

  // input beat split into axes
  logic [2:0][31:0] in_pos, in_anc, in_vel;
  logic signed [32:0] in_d [3];

  assign in_pos = {in_item.pos_z, in_item.pos_y, in_item.pos_x};
  assign in_anc = {in_item.anchor_z, in_item.anchor_y, in_item.anchor_x};
  assign in_vel = {in_item.vel_in_z, in_item.vel_in_y, in_item.vel_in_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_d[i] = $signed({in_pos[i][31], in_pos[i]}) - $signed({in_anc[i][31], in_anc[i]});
    end
  end

  // front stages: difference, squares, sum of squares
  logic              s1_valid, s2_valid, s3_valid;
  side_t             s1_side, s2_side, s3_side;
  logic [SumW-1:0]   s2_sq [3];
  logic [SumW-1:0]   s3_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_side.mag[i] <= in_d[i][32] ? MagW'(-in_d[i]) : MagW'(in_d[i]);
      s1_side.neg[i] <= in_d[i][32];
      s1_side.vel[i] <= in_vel[i];
      s2_sq[i]       <= s1_side.mag[i] * s1_side.mag[i];
    end
    s2_side <= s1_side;
    s3_side <= s2_side;
    s3_sum  <= s2_sq[0] + s2_sq[1] + s2_sq[2];
  end

  // length L = floor(sqrt(sum)), side data delayed alongside
  logic             sq_valid;
  logic [RootW-1:0] sq_root;
  side_t            sq_side [SQRT_LAT];

  spfe_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .radicand  (s3_sum),
    .out_valid (sq_valid),
    .root      (sq_root)
  );

  always_ff @(posedge clk) begin
    sq_side[0] <= s3_side;
    for (int k = 1; k < SQRT_LAT; k++) begin
      sq_side[k] <= sq_side[k-1];
    end
  end

  // unit vector components |d| * 2^30 / L, three dividers in parallel
  logic [QuoW-1:0] dv_q [3];
  dside_t          dv_side [DIV_LAT];
  logic            dv_valid [DIV_LAT];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    spfe_div u_div (
      .clk          (clk),
      .dividend_mag (sq_side[SQRT_LAT-1].mag[a]),
      .divisor      (sq_root),
      .quot         (dv_q[a])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        dv_valid[k] <= 1'b0;
      end
    end else begin
      dv_valid[0] <= sq_valid;
      for (int k = 1; k < DIV_LAT; k++) begin
        dv_valid[k] <= dv_valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dv_side[0].neg <= sq_side[SQRT_LAT-1].neg;
    dv_side[0].vel <= sq_side[SQRT_LAT-1].vel;
    dv_side[0].len <= sq_root;
    for (int k = 1; k < DIV_LAT; k++) begin
      dv_side[k] <= dv_side[k-1];
    end
  end

  // back stages
  dside_t             bk;
  logic signed [33:0] e_val;
  logic [RootW-1:0]   e_mag;

  assign bk    = dv_side[DIV_LAT-1];
  assign e_val = $signed({1'b0, bk.len}) - $signed({3'b000, rest_length});
  assign e_mag = e_val[33] ? RootW'(-e_val) : e_val[RootW-1:0];

  logic             s5_valid, s6_valid, s7_valid, s8_valid, s9_valid;
  logic [47:0]      s5_pa;
  logic [46:0]      s5_pb;
  logic             s5_eneg, s5_zero;
  logic [QuoW-1:0]  s5_q [3];
  logic [2:0]       s5_neg;
  logic [2:0][31:0] s5_vel;

  logic [63:0]      tprod;
  logic [47:0]      s6_tmag;
  logic             s6_tneg, s6_zero;
  logic [QuoW-1:0]  s6_q [3];
  logic [2:0]       s6_neg;
  logic [2:0][31:0] s6_vel;
  logic [31:0]      s6_vmag [3];

  logic [54:0]      s7_pl [3];
  logic [54:0]      s7_ph [3];
  logic [62:0]      s7_dm [3];
  logic             s7_tneg, s7_zero;
  logic [2:0]       s7_neg;
  logic [2:0][31:0] s7_vel;

  logic [78:0]      fprod [3];
  logic [48:0]      s8_fm [3];
  logic [46:0]      s8_dm [3];
  logic [2:0]       s8_pos;
  logic             s8_zero;
  logic [2:0][31:0] s8_vel;

  logic signed [51:0] spr [3];
  logic signed [51:0] drg [3];
  logic signed [51:0] grv [3];
  logic signed [51:0] s9_acc [3];
  logic               s9_zero;
  logic [2:0][31:0]   s9_vel;

  logic [31:0] sat_acc [3];

  assign tprod = ({17'b0, s5_pb} << 17) + {16'b0, s5_pa};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s6_vmag[i] = s6_vel[i][31] ? 32'(-$signed(s6_vel[i])) : s6_vel[i];
      fprod[i]   = {s7_ph[i], 24'b0} + {24'b0, s7_pl[i]};
      spr[i]     = s8_zero ? '0 :
                   (s8_pos[i] ? $signed({3'b000, s8_fm[i]}) : -$signed({3'b000, s8_fm[i]}));
      drg[i]     = s8_vel[i][31] ? $signed({5'b0, s8_dm[i]}) : -$signed({5'b0, s8_dm[i]});
      grv[i]     = (i == 1) ? $signed({21'b0, gravity_accel}) : '0;
      if (s9_acc[i] > 52'sd2147483647) begin
        sat_acc[i] = 32'h7fff_ffff;
      end else if (s9_acc[i] < -52'sd2147483648) begin
        sat_acc[i] = 32'h8000_0000;
      end else begin
        sat_acc[i] = s9_acc[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
      s9_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s5_valid <= dv_valid[DIV_LAT-1];
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
      s8_valid <= s7_valid;
      s9_valid <= s8_valid;
      done     <= s9_valid;
    end
  end

  always_ff @(posedge clk) begin
    // tension k*|L - rest| as two narrow partial products
    s5_pa   <= spring_stiffness * e_mag[16:0];
    s5_pb   <= spring_stiffness * e_mag[32:17];
    s5_eneg <= e_val[33];
    s5_zero <= (bk.len == '0);
    s5_neg  <= bk.neg;
    s5_vel  <= bk.vel;
    for (int i = 0; i < 3; i++) begin
      s5_q[i] <= dv_q[i];
    end

    s6_tmag <= tprod[63:16];
    s6_tneg <= s5_eneg;
    s6_zero <= s5_zero;
    s6_neg  <= s5_neg;
    s6_vel  <= s5_vel;
    for (int i = 0; i < 3; i++) begin
      s6_q[i] <= s5_q[i];
    end

    // spring magnitude |T|*|U| split on the tension, drag d*|v|
    for (int i = 0; i < 3; i++) begin
      s7_pl[i] <= s6_tmag[23:0] * s6_q[i];
      s7_ph[i] <= s6_tmag[47:24] * s6_q[i];
      s7_dm[i] <= drag_coeff * s6_vmag[i];
    end
    s7_tneg <= s6_tneg;
    s7_zero <= s6_zero;
    s7_neg  <= s6_neg;
    s7_vel  <= s6_vel;

    for (int i = 0; i < 3; i++) begin
      s8_fm[i]  <= fprod[i][78:30];
      s8_dm[i]  <= s7_dm[i][62:16];
      s8_pos[i] <= s7_tneg ^ s7_neg[i];
    end
    s8_zero <= s7_zero;
    s8_vel  <= s7_vel;

    for (int i = 0; i < 3; i++) begin
      s9_acc[i] <= spr[i] + drg[i] - grv[i];
    end
    s9_zero <= s8_zero;
    s9_vel  <= s8_vel;

    result.vel_out_x   <= s9_vel[0];
    result.vel_out_y   <= s9_vel[1];
    result.vel_out_z   <= s9_vel[2];
    result.accel_x     <= sat_acc[0];
    result.accel_y     <= sat_acc[1];
    result.accel_z     <= sat_acc[2];
    result.zero_length <= s9_zero;
  end

  // a result strobe always traces back to an accepted beat
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result beat without matching input beat");

  // velocity pass-through stays aligned with its item
  a_vel_aligned: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.vel_out_x == $past(in_item.vel_in_x, TOTAL_LAT)) &&
             (result.vel_out_y == $past(in_item.vel_in_y, TOTAL_LAT)) &&
             (result.vel_out_z == $past(in_item.vel_in_z, TOTAL_LAT)))
    else $error("velocity misaligned with result beat");

  // zero length only when the positions coincided
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    (done && result.zero_length) |->
      $past((in_item.pos_x == in_item.anchor_x) && (in_item.pos_y == in_item.anchor_y) &&
            (in_item.pos_z == in_item.anchor_z), TOTAL_LAT))
    else $error("zero length flag on distinct positions");

endmodule
